[rtl/crc16_frame_append_check_macros.svh]
// ----------------------------------------------------------------------------
// CRC-16 frame append/check assertion macros
// Shared concurrent assertion helpers for the CRC-16 frame block.
// ----------------------------------------------------------------------------
`ifndef CRC16_FRAME_APPEND_CHECK_MACROS_SVH
`define CRC16_FRAME_APPEND_CHECK_MACROS_SVH

`ifndef ASSERT_OFF

// Property holds at every clock edge outside reset.
`define CRCFA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define CRCFA_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define CRCFA_ASSERT(lbl, clk, rst_n, prop, msg)
`define CRCFA_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

[rtl/crcfa_pkg.sv]
// ----------------------------------------------------------------------------
// CRC-16 frame append/check package
// Payload types, result codes and the byte-wide CRC-16 (0x1021) update.
// ----------------------------------------------------------------------------
package crcfa_pkg;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_CHECK  = 1'b1;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_CRC     = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_SHORT    = 2'd2;

    localparam int GRP_DEPTH = 3;

    typedef struct packed {
        logic [7:0]  in_byte;
        logic        opcode;
        logic        first_of_frame;
        logic        last_of_frame;
        logic [15:0] seed;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
        logic [1:0] check_status;
        logic       end_of_run;
    } t_out_item;

    // Results caused by one input byte, oldest in slot 0.
    typedef struct packed {
        logic [1:0]                     n;
        t_out_item [GRP_DEPTH-1:0]      items;
    } t_grp;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[rtl/crcfa_core.sv]
// ----------------------------------------------------------------------------
// CRC-16 frame core
// Input register, frame state and the single-pass CRC/append/check logic.
// ----------------------------------------------------------------------------
module crcfa_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  crcfa_pkg::t_in_item i_in_item,
    output logic                o_grp_valid,
    input  logic                i_grp_ready,
    output crcfa_pkg::t_grp     o_grp
);

    logic                r_in_valid;
    crcfa_pkg::t_in_item r_in;

    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_h0, n_h0;
    logic [7:0]  r_h1, n_h1;
    logic [1:0]  r_cnt, n_cnt;
    logic        r_mode, n_mode;

    logic        w_accept;
    logic        w_advance;
    logic [15:0] w_crc0;
    logic [1:0]  w_cnt0;
    logic [7:0]  w_crc_in;
    logic [15:0] w_crc_upd;
    logic [1:0]  w_st;
    crcfa_pkg::t_grp w_grp;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_advance   = r_in_valid && i_grp_ready;
    assign o_in_ready  = !r_in_valid || i_grp_ready;
    assign o_grp_valid = r_in_valid;
    assign o_grp       = w_grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= '0;
            r_h0   <= '0;
            r_h1   <= '0;
            r_cnt  <= '0;
            r_mode <= crcfa_pkg::OP_APPEND;
        end else if (w_advance) begin
            r_crc  <= n_crc;
            r_h0   <= n_h0;
            r_h1   <= n_h1;
            r_cnt  <= n_cnt;
            r_mode <= n_mode;
        end
    end

    // One CRC unit: the new byte in append mode, the oldest held byte in check mode.
    assign w_crc_in  = (n_mode == crcfa_pkg::OP_APPEND) ? r_in.in_byte : r_h0;
    assign w_crc_upd = crcfa_pkg::crc_byte(w_crc0, w_crc_in);

    always_comb begin
        n_mode = r_in.first_of_frame ? r_in.opcode : r_mode;
        w_crc0 = r_in.first_of_frame ? r_in.seed : r_crc;
        w_cnt0 = r_in.first_of_frame ? 2'd0 : r_cnt;
        n_crc  = w_crc0;
        n_h0   = r_h0;
        n_h1   = r_h1;
        n_cnt  = w_cnt0;
        w_st   = crcfa_pkg::ST_OK;
        w_grp  = '0;

        if (n_mode == crcfa_pkg::OP_APPEND) begin
            n_crc = w_crc_upd;
            w_grp.items[0] = '{r_in.in_byte, crcfa_pkg::KIND_PAYLOAD, crcfa_pkg::ST_OK, 1'b0};
            w_grp.n = 2'd1;
            if (r_in.last_of_frame) begin
                w_grp.items[1] = '{w_crc_upd[15:8], crcfa_pkg::KIND_CRC,
                                   crcfa_pkg::ST_OK, 1'b0};
                w_grp.items[2] = '{w_crc_upd[7:0], crcfa_pkg::KIND_CRC,
                                   crcfa_pkg::ST_OK, 1'b1};
                w_grp.n = 2'd3;
                n_cnt = 2'd0;
            end
        end else begin
            if (w_cnt0 < 2'd2) begin
                if (w_cnt0[0]) begin
                    n_h1 = r_in.in_byte;
                end else begin
                    n_h0 = r_in.in_byte;
                end
                n_cnt = w_cnt0 + 2'd1;
            end else begin
                n_crc = w_crc_upd;
                n_h0  = r_h1;
                n_h1  = r_in.in_byte;
                w_grp.items[0] = '{r_h0, crcfa_pkg::KIND_PAYLOAD, crcfa_pkg::ST_OK, 1'b0};
                w_grp.n = 2'd1;
            end
            if (r_in.last_of_frame) begin
                if (n_cnt < 2'd2) begin
                    w_st = crcfa_pkg::ST_SHORT;
                end else if ({n_h0, n_h1} == n_crc) begin
                    w_st = crcfa_pkg::ST_OK;
                end else begin
                    w_st = crcfa_pkg::ST_MISMATCH;
                end
                if (w_grp.n == 2'd0) begin
                    w_grp.items[0] = '{8'h00, crcfa_pkg::KIND_STATUS, w_st, 1'b1};
                end else begin
                    w_grp.items[1] = '{8'h00, crcfa_pkg::KIND_STATUS, w_st, 1'b1};
                end
                w_grp.n = w_grp.n + 2'd1;
                n_cnt = 2'd0;
            end
        end
    end

endmodule

[rtl/crcfa_out.sv]
// ----------------------------------------------------------------------------
// CRC-16 frame result register
// Holds the results of one byte and hands them out one transfer at a time.
// ----------------------------------------------------------------------------
`include "crc16_frame_append_check_macros.svh"

module crcfa_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_grp_valid,
    output logic                 o_grp_ready,
    input  crcfa_pkg::t_grp      i_grp,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output crcfa_pkg::t_out_item o_out_item
);

    crcfa_pkg::t_out_item [crcfa_pkg::GRP_DEPTH-1:0] r_items;
    logic [1:0] r_cnt;
    logic       w_take;
    logic       w_load;

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_item  = r_items[0];
    assign w_take      = o_out_valid && i_out_ready;
    assign o_grp_ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_out_ready);
    assign w_load      = i_grp_valid && o_grp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (w_load) begin
            r_cnt <= i_grp.n;
        end else if (w_take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_items <= i_grp.items;
        end else if (w_take) begin
            r_items[0] <= r_items[1];
            r_items[1] <= r_items[2];
        end
    end

    `CRCFA_ASSERT(a_cnt_step, i_clk, i_rst_n, (w_take && r_cnt > 2'd1) |=> (r_cnt == $past(r_cnt) - 2'd1), "result count did not step down")
    `CRCFA_ASSERT(a_eor_last, i_clk, i_rst_n, (o_out_valid && r_items[0].end_of_run) |-> (r_cnt == 2'd1), "end of run before last result")
    `CRCFA_NEVER(a_status_byte, i_clk, i_rst_n, o_out_valid && r_items[0].out_kind == crcfa_pkg::KIND_STATUS && r_items[0].out_byte != 8'h00, "status result with nonzero byte")

endmodule

[rtl/crc16_frame_append_check.sv]
// Path: an input byte is registered in the core input register, then its results in
// the result register, from which they are valid at the output.
// Throughput: one byte per cycle while the output accepts; set by the result register,
// which hands out one result per cycle: a last byte in append mode gives three results
// and a last byte in check mode one or two, and input is held until they are handed out.
// Reset: synchronous, active low; clears CRC, held bytes, count, mode (append).
// ----------------------------------------------------------------------------
// CRC-16 frame append/check
// CRC-16 (0x1021, MSB first) append or trailer check over framed byte streams.
// ----------------------------------------------------------------------------
module crc16_frame_append_check (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  crcfa_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output crcfa_pkg::t_out_item o_out_item
);

    logic            w_grp_valid;
    logic            w_grp_ready;
    crcfa_pkg::t_grp w_grp;

    crcfa_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_grp_valid (w_grp_valid),
        .i_grp_ready (w_grp_ready),
        .o_grp       (w_grp)
    );

    crcfa_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp_valid (w_grp_valid),
        .o_grp_ready (w_grp_ready),
        .i_grp       (w_grp),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
